[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is low
`define CCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define CCL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ccl_pkg.sv]
// shared types, codes and widths for the connected component labeling block
// no dependencies
package ccl_pkg;

  localparam int OP_W   = 2;
  localparam int VTX_W  = 10;
  localparam int LBL_W  = 10;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 2;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES    = 4096;
  localparam int COUNT_LIMIT      = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // register byte addresses
  localparam logic [CFG_AW-1:0] REG_VCOUNT = 2'd0;

  typedef struct packed {
    logic             go;
    logic [OP_W-1:0]  op;
    logic [VTX_W-1:0] vtx_a;
    logic [VTX_W-1:0] vtx_b;
  } ccl_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LBL_W-1:0] label;
  } ccl_rsp_t;

endpackage

[rtl/connected_component_labeling_top.sv]
// top level of the connected component labeling block: command port,
// config register, edge count and result register; depends on ccl_pkg, ccl_core
//
// Commands are taken when start is high and busy is low; every command gives
// exactly one result word, shown on out_label/out_status for one cycle with
// out_valid high, and the receiver cannot stall it. Clear, add edge and an
// out-of-range read answer in the cycle after the command and the next
// command may follow at once. A valid read holds busy for the memory read and
// then the result. A solve holds busy until its connect rounds and shortcut
// passes settle: one shared comparator and label, snapshot and edge memories
// with one read port each handle one element per step.
// After reset the label memory is swept back to identity with busy high;
// config writes are taken meanwhile.
module connected_component_labeling_top #(
  parameter int MAX_VERTICES = ccl_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ccl_pkg::DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [ccl_pkg::OP_W-1:0]    in_operation,
  input  logic [ccl_pkg::VTX_W-1:0]   in_vertex_a,
  input  logic [ccl_pkg::VTX_W-1:0]   in_vertex_b,
  // result channel
  output logic                        out_valid,
  output logic [ccl_pkg::LBL_W-1:0]   out_label,
  output logic [ccl_pkg::STAT_W-1:0]  out_status,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccl_pkg::CFG_AW-1:0]  paddr,
  input  logic [ccl_pkg::CFG_DW-1:0]  pwdata,
  output logic [ccl_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import ccl_pkg::*;

  localparam int ET_W = $clog2(MAX_EDGES+1);
  localparam logic [CNT_W-1:0] COUNT_CAP =
    CNT_W'((MAX_VERTICES < COUNT_LIMIT) ? MAX_VERTICES : COUNT_LIMIT);

  // config register: vertices in use, saturated on write, a zero write gives one
  logic [CNT_W-1:0] vcount_r;
  logic             cfg_wr;
  logic [CNT_W-1:0] cfg_val;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_VCOUNT);
  assign cfg_val = pwdata[CNT_W-1:0];
  assign prdata = (paddr == REG_VCOUNT) ? {{(CFG_DW-CNT_W){1'b0}}, vcount_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= COUNT_CAP;
    end else if (cfg_wr) begin
      if (cfg_val == '0) begin
        vcount_r <= CNT_W'(1);
      end else if (cfg_val > COUNT_CAP) begin
        vcount_r <= COUNT_CAP;
      end else begin
        vcount_r <= cfg_val;
      end
    end
  end

  // command decode
  ccl_req_t          req;
  ccl_rsp_t          rsp;
  logic              accept;
  logic              a_ok, b_ok, full;
  logic              imm;
  logic [STAT_W-1:0] imm_st;
  logic [ET_W-1:0]   edge_total_r, edge_total_nxt;

  assign busy   = rsp.busy || rsp.done;
  assign accept = start && !busy;
  assign a_ok   = {1'b0, in_vertex_a} < vcount_r;
  assign b_ok   = {1'b0, in_vertex_b} < vcount_r;
  assign full   = (edge_total_r == ET_W'(MAX_EDGES));

  always_comb begin
    req.go         = 1'b0;
    req.op         = in_operation;
    req.vtx_a      = in_vertex_a;
    req.vtx_b      = in_vertex_b;
    imm            = 1'b0;
    imm_st         = ST_OK;
    edge_total_nxt = edge_total_r;
    if (accept) begin
      case (in_operation)
        OP_CLEAR: begin
          // labels stay, only the edge count drops
          imm            = 1'b1;
          edge_total_nxt = '0;
        end
        OP_ADD: begin
          imm = 1'b1;
          if (!(a_ok && b_ok)) begin
            imm_st = ST_RANGE;
          end else if (full) begin
            imm_st = ST_FULL;
          end else begin
            req.go         = 1'b1;
            edge_total_nxt = edge_total_r + ET_W'(1);
          end
        end
        OP_SOLVE: req.go = 1'b1;
        OP_READ: begin
          if (!a_ok) begin
            imm    = 1'b1;
            imm_st = ST_RANGE;
          end else begin
            req.go = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
    end else begin
      edge_total_r <= edge_total_nxt;
    end
  end

  ccl_core #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .vcount     (vcount_r),
    .edge_total (edge_total_r),
    .rsp        (rsp)
  );

  // result word register, one cycle strobe
  logic              out_valid_r;
  logic [LBL_W-1:0]  out_label_r;
  logic [STAT_W-1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= imm || rsp.done;
    end
  end

  always_ff @(posedge clk) begin
    out_label_r  <= rsp.done ? rsp.label : '0;
    out_status_r <= imm ? imm_st : ST_OK;
  end

  assign out_valid  = out_valid_r;
  assign out_label  = out_label_r;
  assign out_status = out_status_r;

endmodule

[rtl/ccl_core.sv]
// label engine: edge store, label and snapshot memories, solve sequencer
// depends on ccl_pkg
module ccl_core #(
  parameter int MAX_VERTICES = ccl_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ccl_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ccl_pkg::ccl_req_t                req,
  input  logic [ccl_pkg::CNT_W-1:0]        vcount,
  input  logic [$clog2(MAX_EDGES+1)-1:0]   edge_total,
  output ccl_pkg::ccl_rsp_t                rsp
);
  import ccl_pkg::*;

  localparam int LDEPTH = (MAX_VERTICES < COUNT_LIMIT) ? MAX_VERTICES : COUNT_LIMIT;
  localparam int LA_W   = $clog2(LDEPTH);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W   = $clog2(MAX_EDGES+1);
  localparam int ED_W   = 2*VTX_W;

  localparam logic [3:0] S_WIPE   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDLBL  = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_COPY   = 4'd4;
  localparam logic [3:0] S_EFETCH = 4'd5;
  localparam logic [3:0] S_EA     = 4'd6;
  localparam logic [3:0] S_EB     = 4'd7;
  localparam logic [3:0] S_EROOT  = 4'd8;
  localparam logic [3:0] S_ELOWER = 4'd9;
  localparam logic [3:0] S_SRD    = 4'd10;
  localparam logic [3:0] S_SUP    = 4'd11;
  localparam logic [3:0] S_SWR    = 4'd12;

  // memories
  logic [ED_W-1:0]  edge_mem [MAX_EDGES];
  logic [LBL_W-1:0] par_mem  [LDEPTH];
  logic [LBL_W-1:0] snap_mem [LDEPTH];

  logic [ED_W-1:0]  edge_rdata_r;
  logic [LBL_W-1:0] par_rdata_r;
  logic [LBL_W-1:0] snap_rdata_r;

  logic             edge_we;
  logic [EA_W-1:0]  edge_raddr;
  logic             par_we;
  logic [LA_W-1:0]  par_waddr, par_raddr;
  logic [LBL_W-1:0] par_wdata;
  logic             snap_we;
  logic [LA_W-1:0]  snap_waddr, snap_raddr;
  logic [LBL_W-1:0] snap_wdata;

  // sequencer registers
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] v_r, v_nxt;
  logic [ET_W-1:0]  e_r, e_nxt;
  logic             cp_vld_r, cp_vld_nxt;
  logic [LA_W-1:0]  cp_addr_r, cp_addr_nxt;
  logic             cp_conn_r, cp_conn_nxt;
  logic [LBL_W-1:0] ra_r, ra_nxt;
  logic [LBL_W-1:0] root_r, root_nxt;
  logic [LBL_W-1:0] cand_r, cand_nxt;
  logic [LBL_W-1:0] up_r, up_nxt;
  logic             chg_r, chg_nxt;
  logic             sc_chg_r, sc_chg_nxt;
  logic             done_r, done_nxt;
  logic [LBL_W-1:0] label_r, label_nxt;

  // shared compare unit
  logic [CNT_W-1:0] cmp_x, cmp_y;
  logic             cmp_lt;
  assign cmp_lt = cmp_x < cmp_y;

  logic [VTX_W-1:0] ed_a, ed_b;
  assign ed_a = edge_rdata_r[VTX_W-1:0];
  assign ed_b = edge_rdata_r[ED_W-1:VTX_W];

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total[EA_W-1:0]] <= {req.vtx_b, req.vtx_a};
    end
    edge_rdata_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata_r <= par_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[snap_waddr] <= snap_wdata;
    end
    snap_rdata_r <= snap_mem[snap_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    v_nxt       = v_r;
    e_nxt       = e_r;
    cp_vld_nxt  = cp_vld_r;
    cp_addr_nxt = cp_addr_r;
    cp_conn_nxt = cp_conn_r;
    ra_nxt      = ra_r;
    root_nxt    = root_r;
    cand_nxt    = cand_r;
    up_nxt      = up_r;
    chg_nxt     = chg_r;
    sc_chg_nxt  = sc_chg_r;
    done_nxt    = 1'b0;
    label_nxt   = label_r;
    edge_we     = req.go && (req.op == OP_ADD) && (state_r == S_IDLE);
    edge_raddr  = e_r[EA_W-1:0];
    par_we      = 1'b0;
    par_waddr   = v_r[LA_W-1:0];
    par_wdata   = v_r[LBL_W-1:0];
    par_raddr   = v_r[LA_W-1:0];
    snap_we     = cp_vld_r;
    snap_waddr  = cp_addr_r;
    snap_wdata  = par_rdata_r;
    snap_raddr  = v_r[LA_W-1:0];
    cmp_x       = '0;
    cmp_y       = '0;
    case (state_r)
      S_WIPE: begin
        // every label entry back to its own index
        par_we = 1'b1;
        if (v_r == CNT_W'(LDEPTH-1)) begin
          v_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      S_IDLE: begin
        par_raddr = req.vtx_a[LA_W-1:0];
        if (req.go) begin
          case (req.op)
            OP_SOLVE: begin
              v_nxt     = '0;
              state_nxt = S_INIT;
            end
            OP_READ:  state_nxt = S_RDLBL;
            default:  ;
          endcase
        end
      end
      S_RDLBL: begin
        done_nxt  = 1'b1;
        label_nxt = par_rdata_r;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        if (v_r == vcount) begin
          v_nxt       = '0;
          cp_conn_nxt = 1'b1;
          cp_vld_nxt  = 1'b0;
          state_nxt   = S_COPY;
        end else begin
          par_we = 1'b1;
          v_nxt  = v_r + 1'b1;
        end
      end
      S_COPY: begin
        // read label v, write snapshot in the cycle after
        if (v_r != vcount) begin
          cp_vld_nxt  = 1'b1;
          cp_addr_nxt = v_r[LA_W-1:0];
          v_nxt       = v_r + 1'b1;
        end else begin
          cp_vld_nxt = 1'b0;
          if (!cp_vld_r) begin
            if (cp_conn_r) begin
              e_nxt     = '0;
              chg_nxt   = 1'b0;
              state_nxt = S_EFETCH;
            end else begin
              v_nxt      = '0;
              sc_chg_nxt = 1'b0;
              state_nxt  = S_SRD;
            end
          end
        end
      end
      S_EFETCH: begin
        if (e_r == edge_total) begin
          v_nxt       = '0;
          cp_conn_nxt = 1'b0;
          cp_vld_nxt  = 1'b0;
          state_nxt   = S_COPY;
        end else begin
          state_nxt = S_EA;
        end
      end
      S_EA: begin
        cmp_x      = {1'b0, ed_a};
        cmp_y      = vcount;
        snap_raddr = ed_a[LA_W-1:0];
        if (cmp_lt) begin
          state_nxt = S_EB;
        end else begin
          e_nxt     = e_r + 1'b1;
          state_nxt = S_EFETCH;
        end
      end
      S_EB: begin
        cmp_x      = {1'b0, ed_b};
        cmp_y      = vcount;
        snap_raddr = ed_b[LA_W-1:0];
        if (cmp_lt) begin
          ra_nxt    = snap_rdata_r;
          state_nxt = S_EROOT;
        end else begin
          e_nxt     = e_r + 1'b1;
          state_nxt = S_EFETCH;
        end
      end
      S_EROOT: begin
        // larger root gets lowered to the smaller one
        cmp_x = {1'b0, snap_rdata_r};
        cmp_y = {1'b0, ra_r};
        if (cmp_lt) begin
          root_nxt = ra_r;
          cand_nxt = snap_rdata_r;
        end else begin
          root_nxt = snap_rdata_r;
          cand_nxt = ra_r;
        end
        par_raddr = root_nxt[LA_W-1:0];
        state_nxt = S_ELOWER;
      end
      S_ELOWER: begin
        cmp_x = {1'b0, cand_r};
        cmp_y = {1'b0, par_rdata_r};
        if (cmp_lt) begin
          par_we    = 1'b1;
          par_waddr = root_r[LA_W-1:0];
          par_wdata = cand_r;
          chg_nxt   = 1'b1;
        end
        e_nxt     = e_r + 1'b1;
        state_nxt = S_EFETCH;
      end
      S_SRD: begin
        if (v_r == vcount) begin
          v_nxt      = '0;
          cp_vld_nxt = 1'b0;
          if (sc_chg_r) begin
            cp_conn_nxt = 1'b0;
            state_nxt   = S_COPY;
          end else if (chg_r) begin
            cp_conn_nxt = 1'b1;
            state_nxt   = S_COPY;
          end else begin
            done_nxt  = 1'b1;
            label_nxt = '0;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SUP;
        end
      end
      S_SUP: begin
        cmp_x      = {1'b0, snap_rdata_r};
        cmp_y      = vcount;
        up_nxt     = snap_rdata_r;
        snap_raddr = snap_rdata_r[LA_W-1:0];
        if (cmp_lt) begin
          state_nxt = S_SWR;
        end else begin
          par_we    = 1'b1;
          par_wdata = snap_rdata_r;
          v_nxt     = v_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SWR: begin
        par_we    = 1'b1;
        par_wdata = snap_rdata_r;
        if (snap_rdata_r != up_r) begin
          sc_chg_nxt = 1'b1;
        end
        v_nxt     = v_r + 1'b1;
        state_nxt = S_SRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_WIPE;
      v_r       <= '0;
      e_r       <= '0;
      cp_vld_r  <= 1'b0;
      cp_conn_r <= 1'b0;
      chg_r     <= 1'b0;
      sc_chg_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      v_r       <= v_nxt;
      e_r       <= e_nxt;
      cp_vld_r  <= cp_vld_nxt;
      cp_conn_r <= cp_conn_nxt;
      chg_r     <= chg_nxt;
      sc_chg_r  <= sc_chg_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    ra_r      <= ra_nxt;
    root_r    <= root_nxt;
    cand_r    <= cand_nxt;
    up_r      <= up_nxt;
    label_r   <= label_nxt;
  end

  assign rsp.busy  = (state_r != S_IDLE);
  assign rsp.done  = done_r;
  assign rsp.label = label_r;

endmodule

[rtl/ccl_checker.sv]
// port-level assertions for the labeling block, bound to the top level
// depends on ccl_pkg and assert_macros.svh
`include "assert_macros.svh"

module ccl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [ccl_pkg::OP_W-1:0]    in_operation,
  input logic                        out_valid,
  input logic [ccl_pkg::LBL_W-1:0]   out_label,
  input logic [ccl_pkg::STAT_W-1:0]  out_status
);
  import ccl_pkg::*;

  // clear always answers ok in the next cycle
  `CCL_ASSERT(a_clear_word, (start && !busy && in_operation == OP_CLEAR) |=> (out_valid && out_status == ST_OK && out_label == '0), "clear word missing or wrong")
  // a solve holds the block busy
  `CCL_ASSERT(a_solve_busy, (start && !busy && in_operation == OP_SOLVE) |=> (busy && !out_valid), "solve not busy")
  // an error word carries no label
  `CCL_ASSERT(a_err_label, (out_valid && out_status != ST_OK) |-> (out_label == '0), "label on error word")
  // reset starts the label sweep with no word out
  `CCL_ASSERT_RST(a_reset_sweep, !rst_n |=> (busy && !out_valid), "no sweep after reset")

endmodule

bind connected_component_labeling_top ccl_checker u_ccl_checker (.*);

[dv/tb.sv]
// self-checking testbench for connected_component_labeling_top: directed table,
// stale edge check, then random graph sessions checked against a built-in predictor
// depends on ccl_pkg and connected_component_labeling_top
module tb;
  import ccl_pkg::*;

  // vertex limit as the block clamps it, and the edge store depth
  localparam int VTX_CAP      = (DEF_MAX_VERTICES < COUNT_LIMIT) ? DEF_MAX_VERTICES : COUNT_LIMIT;
  localparam int EDGE_CAP     = DEF_MAX_EDGES;
  localparam int RANDOM_ITEMS = 90;
  localparam int REPORT_MAX   = 10;
  // bound well above the slowest legal run (a handful of
  // solves at 1024 vertices with full idle gaps)
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int N_DIR        = 24;

  // one result word as the receiver sees it
  typedef struct packed {
    logic [LBL_W-1:0]  label;
    logic [STAT_W-1:0] status;
  } ccl_word_t;

  // directed rows either issue a command or rewrite vertex_count
  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [VTX_W-1:0]  vtx_a;
    logic [VTX_W-1:0]  vtx_b;
    logic [CFG_DW-1:0] value;
    logic              typed;
    logic [LBL_W-1:0]  exp_label;
    logic [STAT_W-1:0] exp_status;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  // all block inputs start at known values
  logic               start = 1'b0;
  logic [OP_W-1:0]    in_operation = OP_CLEAR;
  logic [VTX_W-1:0]   in_vertex_a = '0;
  logic [VTX_W-1:0]   in_vertex_b = '0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = REG_VCOUNT;
  logic [CFG_DW-1:0]  pwdata = '0;

  logic               busy;
  logic               out_valid;
  logic [LBL_W-1:0]   out_label;
  logic [STAT_W-1:0]  out_status;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // predictor state: edge list, label memory, snapshot and vertex count
  logic [VTX_W-1:0]   edge_a [EDGE_CAP];
  logic [VTX_W-1:0]   edge_b [EDGE_CAP];
  int                 edge_cnt;
  logic [LBL_W-1:0]   lbl_mem [VTX_CAP];
  logic [LBL_W-1:0]   lbl_snap [VTX_CAP];
  int                 vcount;

  // words the block still owes, oldest first
  ccl_word_t          pending_words [$];
  int                 failures = 0;
  int                 word_idx = 0;
  int                 cycle_cnt = 0;
  int                 item_count = 0;
  bit                 burst_mode = 1'b0;

  dir_row_t           dir_tab [N_DIR];

  connected_component_labeling_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_vertex_a  (in_vertex_a),
    .in_vertex_b  (in_vertex_b),
    .out_valid    (out_valid),
    .out_label    (out_label),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs or drops a word
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // label solve: identity start, then parent-connect rounds, each followed by
  // shortcut passes until they settle; repeat while a connect lowered a label
  function automatic void solve_components();
    int n;
    bit connect_moved;
    bit shortcut_moved;
    logic [LBL_W-1:0] ra;
    logic [LBL_W-1:0] rb;
    logic [LBL_W-1:0] up;
    logic [LBL_W-1:0] nxt;
    n = vcount;
    for (int v = 0; v < n; v++) lbl_mem[v] = LBL_W'(v);
    do begin
      connect_moved = 1'b0;
      for (int v = 0; v < n; v++) lbl_snap[v] = lbl_mem[v];
      for (int e = 0; e < edge_cnt; e++) begin
        // edges stored under a larger vertex count are skipped
        if (edge_a[e] >= n || edge_b[e] >= n) continue;
        ra = lbl_snap[edge_a[e]];
        rb = lbl_snap[edge_b[e]];
        if (ra > rb) begin
          if (rb < lbl_mem[ra]) begin
            lbl_mem[ra] = rb;
            connect_moved = 1'b1;
          end
        end else if (ra < lbl_mem[rb]) begin
          lbl_mem[rb] = ra;
          connect_moved = 1'b1;
        end
      end
      do begin
        shortcut_moved = 1'b0;
        for (int v = 0; v < n; v++) lbl_snap[v] = lbl_mem[v];
        for (int v = 0; v < n; v++) begin
          up = lbl_snap[v];
          nxt = (up < n) ? lbl_snap[up] : up;
          lbl_mem[v] = nxt;
          if (nxt != up) shortcut_moved = 1'b1;
        end
      end while (shortcut_moved);
    end while (connect_moved);
  endfunction

  // result word for one command, updating the predictor state
  function automatic ccl_word_t predict_word(input logic [OP_W-1:0] op,
                                             input logic [VTX_W-1:0] va,
                                             input logic [VTX_W-1:0] vb);
    ccl_word_t w;
    w = '0;
    w.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        // only the edge count goes, labels stay
        edge_cnt = 0;
      end
      OP_ADD: begin
        // range check wins over the full check
        if (va >= vcount || vb >= vcount) begin
          w.status = ST_RANGE;
        end else if (edge_cnt >= EDGE_CAP) begin
          w.status = ST_FULL;
        end else begin
          edge_a[edge_cnt] = va;
          edge_b[edge_cnt] = vb;
          edge_cnt++;
        end
      end
      OP_SOLVE: begin
        solve_components();
      end
      default: begin
        if (va >= vcount) w.status = ST_RANGE;
        else w.label = lbl_mem[va];
      end
    endcase
    return w;
  endfunction

  // one command: optional idle gap, hold start until the block takes it,
  // then queue the expected word (typed-in or from the predictor)
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] va,
                               input logic [VTX_W-1:0] vb, input bit typed,
                               input ccl_word_t typed_word);
    int gap;
    ccl_word_t model_word;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_vertex_a <= va;
    in_vertex_b <= vb;
    do @(posedge clk); while (busy);
    // taken at this edge; start stays high in case the next word follows at once
    model_word = predict_word(op, va, vb);
    if (typed) model_word = typed_word;
    pending_words.insert(pending_words.size(), model_word);
    item_count++;
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] va,
                       input logic [VTX_W-1:0] vb);
    issue_command(op, va, vb, 1'b0, '0);
  endtask

  // drop start and wait until every owed word has come back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // apb write of vertex_count, setup then access phase
  task automatic write_vertex_count(input logic [CFG_DW-1:0] value);
    int n;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_VCOUNT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // only the low 11 bits count, then clamp to 1 .. vertex limit
    n = int'(value[CNT_W-1:0]);
    vcount = (n < 1) ? 1 : ((n > VTX_CAP) ? VTX_CAP : n);
  endtask

  // endpoint in range most of the time, else any 10-bit value
  function automatic logic [VTX_W-1:0] pick_vertex();
    if ($urandom_range(0, 7) == 0) return VTX_W'($urandom);
    return VTX_W'($urandom_range(0, vcount - 1));
  endfunction

  // result checker: one word per strobe, compared with the oldest expectation
  always @(posedge clk) begin
    ccl_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected word %0d: label %0d status %0d",
                   word_idx, out_label, out_status);
      end else begin
        want = pending_words.pop_front();
        if (out_label !== want.label || out_status !== want.status) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("mismatch on word %0d: label exp %0d got %0d, status exp %0d got %0d",
                     word_idx, want.label, out_label, want.status, out_status);
        end
      end
      word_idx++;
    end
  end

  initial begin
    int base;
    int n_edges;
    int n_reads;
    int n_noise;
    int pick;
    int big_runs;
    logic [CFG_DW-1:0] cfg_val;

    // predictor reset: identity labels, empty store, full vertex count
    for (int v = 0; v < VTX_CAP; v++) begin
      lbl_mem[v] = LBL_W'(v);
      lbl_snap[v] = '0;
    end
    edge_cnt = 0;
    vcount = VTX_CAP;
    big_runs = 0;

    // directed table; typed rows carry an expectation readable at a glance,
    // the rest go through the predictor
    dir_tab = '{
      // identity labels after reset, both ends of the range
      '{ROW_CMD, OP_READ,  10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd1023, 10'd1023, 32'd0, 1'b1, 10'd1023, ST_OK},
      // extreme endpoints, a self loop, a reversed pair
      '{ROW_CMD, OP_ADD,   10'd0,    10'd1023, 32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_ADD,   10'd1023, 10'd1023, 32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_ADD,   10'd6,    10'd5,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_SOLVE, 10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd1023, 10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd6,    10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd7,    10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      // clear keeps labels in place
      '{ROW_CMD, OP_CLEAR, 10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd5,    10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      // count of zero clamps up to one vertex
      '{ROW_CFG, OP_CLEAR, 10'd0,    10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd0,    10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd1,    10'd0,    32'd0, 1'b1, 10'd0,    ST_RANGE},
      '{ROW_CMD, OP_ADD,   10'd0,    10'd1,    32'd0, 1'b1, 10'd0,    ST_RANGE},
      '{ROW_CMD, OP_ADD,   10'd1,    10'd0,    32'd0, 1'b1, 10'd0,    ST_RANGE},
      '{ROW_CMD, OP_ADD,   10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_SOLVE, 10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      // all-ones write clamps down to the vertex limit
      '{ROW_CFG, OP_CLEAR, 10'd0,    10'd0,    32'hFFFF_FFFF, 1'b0, 10'd0, ST_OK},
      // label of a vertex outside the last solve is left as it was
      '{ROW_CMD, OP_READ,  10'd1023, 10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CMD, OP_SOLVE, 10'd0,    10'd0,    32'd0, 1'b1, 10'd0,    ST_OK},
      '{ROW_CMD, OP_READ,  10'd1023, 10'd0,    32'd0, 1'b0, 10'd0,    ST_OK},
      '{ROW_CFG, OP_CLEAR, 10'd0,    10'd0,    32'd1024, 1'b0, 10'd0, ST_OK},
      '{ROW_CMD, OP_READ,  10'd512,  10'd0,    32'd0, 1'b0, 10'd0,    ST_OK}
    };

    // synchronous reset; the label sweep that follows
    // shows up as busy and the first command simply waits for it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_vertex_count(dir_tab[i].value);
      end else begin
        issue_command(dir_tab[i].op, dir_tab[i].vtx_a, dir_tab[i].vtx_b, dir_tab[i].typed,
                      '{label: dir_tab[i].exp_label, status: dir_tab[i].exp_status});
      end
    end

    // a few edges on 16 vertices
    wait_idle();
    write_vertex_count(32'd16);
    issue(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
    for (int i = 0; i < 12; i++)
      issue(OP_ADD, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)));
    // bad endpoint reports the range error
    issue_command(OP_ADD, 10'd3, 10'd16, 1'b1, '{label: 10'd0, status: ST_RANGE});
    // shrink to 8 vertices so every edge touching 8..15 is stale at solve
    wait_idle();
    write_vertex_count(32'd8);
    issue(OP_SOLVE, VTX_W'($urandom), VTX_W'($urandom));
    for (int v = 0; v <= 8; v++) issue(OP_READ, VTX_W'(v), VTX_W'($urandom));
    issue(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom));

    // random graph sessions: new count, edges, solve, reads, a little noise
    base = item_count;
    while (item_count - base < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0 && big_runs < 2) begin
        // full size is slow, keep it to a couple of sessions
        big_runs++;
        cfg_val = $urandom_range(0, 1) ? 32'd1024 : CFG_DW'($urandom_range(1025, 2047));
      end else if (pick == 1) begin
        cfg_val = 32'd1;
      end else begin
        cfg_val = CFG_DW'($urandom_range(2, 48));
      end
      // junk in the unused upper bits now and then
      if ($urandom_range(0, 1)) cfg_val = ($urandom & ~32'h7FF) | cfg_val;
      write_vertex_count(cfg_val);
      burst_mode = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 3) != 0) issue(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
      n_edges = (vcount >= VTX_CAP) ? $urandom_range(1, 12)
                                     : $urandom_range(1, (2 * vcount < 24) ? 2 * vcount : 24);
      for (int i = 0; i < n_edges; i++) issue(OP_ADD, pick_vertex(), pick_vertex());
      issue(OP_SOLVE, VTX_W'($urandom), VTX_W'($urandom));
      n_reads = $urandom_range(2, 8);
      for (int i = 0; i < n_reads; i++) issue(OP_READ, pick_vertex(), VTX_W'($urandom));
      n_noise = $urandom_range(0, 2);
      for (int i = 0; i < n_noise; i++)
        issue(OP_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    end

    // drain, then give a stray word time to show up
    wait_idle();
    repeat (20) @(posedge clk);
    if (failures == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
